FILE: design/max_subarray_sum_assert.svh
// Assertion macros used by the back part of the maximum run sum block.
`ifndef MAX_SUBARRAY_SUM_ASSERT_SVH
`define MAX_SUBARRAY_SUM_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MSA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MSA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: design/msa_pkg.sv
// Package with the shared types and constants of the maximum run sum block.
package msa_pkg;

  // Widths of the result fields.
  localparam int unsigned SUM_OUT_W = 31;
  localparam int unsigned POS_OUT_W = 17;

  // Largest value the result sum can carry; larger sums saturate to it.
  localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = '1;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classification of one beat, made by the front part.
  typedef struct packed {
    logic is_last;   // final sample of the sequence
    logic counted;   // sample lies within the first MAX_LENGTH of the sequence
  } msa_flags_t;

endpackage

FILE: design/max_subarray_sum.sv
// Top level of the maximum contiguous run sum block: front, queue and back.
// Path of a result: the last beat of a sequence passes through the queue, and the
// back part takes it once the result register is free and loads the result there.
// Throughput: one beat per cycle while the queue is not full; the back part's
// single add, compare and select on the running state sets that figure.
// Reset: rst is synchronous and active high; it clears the position counter, the
// queue, the running state and the result valid flag.
module max_subarray_sum #(
  parameter int unsigned MAX_LENGTH   = 65536,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample,
  input  logic                                  is_last,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [msa_pkg::SUM_OUT_W-1:0]         best_sum,
  output logic [msa_pkg::POS_OUT_W-1:0]         best_start,
  output logic [msa_pkg::POS_OUT_W-1:0]         best_end
);

  // Positions run from 1 to MAX_LENGTH.  A run sum never exceeds MAX_LENGTH times
  // the largest sample magnitude, so SAMPLE_WIDTH plus the position width is enough.
  localparam int unsigned POS_W   = $clog2(MAX_LENGTH + 1);
  localparam int unsigned SUM_W   = SAMPLE_WIDTH + POS_W;
  localparam int unsigned FLAGS_W = $bits(msa_pkg::msa_flags_t);
  localparam int unsigned BEAT_W  = SAMPLE_WIDTH + POS_W + FLAGS_W;

  logic                           accept;
  logic signed [SAMPLE_WIDTH-1:0] beat_sample;
  logic [POS_W-1:0]               beat_pos;
  msa_pkg::msa_flags_t            beat_flags;
  logic [BEAT_W-1:0]              q_head;
  logic                           q_valid;
  logic                           q_take;
  logic signed [SAMPLE_WIDTH-1:0] head_sample;
  logic [POS_W-1:0]               head_pos;
  msa_pkg::msa_flags_t            head_flags;

  // A beat is taken whenever the queue has room; the back part drains it at one beat
  // per cycle except while a last beat waits on an unpopped result, when it fills.
  assign accept = push && !full;

  msa_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .MAX_LENGTH  (MAX_LENGTH),
    .POS_W       (POS_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (accept),
    .sample     (sample),
    .is_last    (is_last),
    .beat_sample(beat_sample),
    .beat_pos   (beat_pos),
    .beat_flags (beat_flags)
  );

  msa_queue #(
    .WIDTH(BEAT_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_data({beat_flags, beat_pos, beat_sample}),
    .rd_en  (q_take),
    .rd_data(q_head),
    .valid  (q_valid),
    .full   (full)
  );

  assign head_sample = q_head[SAMPLE_WIDTH-1:0];
  assign head_pos    = q_head[SAMPLE_WIDTH +: POS_W];
  assign head_flags  = q_head[BEAT_W-1 -: FLAGS_W];

  // The back part runs the scan and holds the result until it is popped.
  msa_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .POS_W       (POS_W),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_sample(head_sample),
    .head_pos   (head_pos),
    .head_flags (head_flags),
    .take       (q_take),
    .pop        (pop),
    .empty      (empty),
    .best_sum   (best_sum),
    .best_start (best_start),
    .best_end   (best_end)
  );

endmodule

FILE: design/msa_front.sv
// Front part: counts positions and classifies each accepted sample.
module msa_front #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned MAX_LENGTH   = 65536,
  parameter int unsigned POS_W        = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           is_last,
  output logic signed [SAMPLE_WIDTH-1:0] beat_sample,
  output logic [POS_W-1:0]               beat_pos,
  output msa_pkg::msa_flags_t            beat_flags
);

  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic             counted;

  // Samples beyond the length limit still end the sequence but add nothing.
  assign counted = position < POS_W'(MAX_LENGTH);

  always_comb begin
    position_next = position;
    if (take) begin
      if (is_last) begin
        position_next = '0;
      end else if (counted) begin
        position_next = position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else begin
      position <= position_next;
    end
  end

  assign beat_sample        = sample;
  assign beat_pos           = position + POS_W'(1);
  assign beat_flags.is_last = is_last;
  assign beat_flags.counted = counted;

endmodule

FILE: design/msa_queue.sv
// Short first-in first-out queue between the front and back parts.
module msa_queue #(
  parameter int unsigned WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             valid,
  output logic             full
);

  localparam int unsigned PTR_W = (msa_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(msa_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(msa_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [msa_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign valid   = count != '0;
  assign full    = count == CNT_W'(msa_pkg::QUEUE_DEPTH);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(msa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(msa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/msa_back.sv
// Back part: the running scan and the result register.
`include "max_subarray_sum_assert.svh"

module msa_back #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned POS_W        = 17,
  parameter int unsigned SUM_W        = 33
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  head_valid,
  input  logic signed [SAMPLE_WIDTH-1:0]        head_sample,
  input  logic [POS_W-1:0]                      head_pos,
  input  msa_pkg::msa_flags_t                   head_flags,
  output logic                                  take,
  input  logic                                  pop,
  output logic                                  empty,
  output logic [msa_pkg::SUM_OUT_W-1:0]         best_sum,
  output logic [msa_pkg::POS_OUT_W-1:0]         best_start,
  output logic [msa_pkg::POS_OUT_W-1:0]         best_end
);

  logic signed [SUM_W-1:0] run_sum;
  logic [POS_W-1:0]        run_start;
  logic signed [SUM_W-1:0] best;
  logic [POS_W-1:0]        best_first;
  logic [POS_W-1:0]        best_last;
  logic                    out_valid;

  logic signed [SUM_W-1:0] run_sum_next;
  logic [POS_W-1:0]        run_start_next;
  logic signed [SUM_W-1:0] best_next;
  logic [POS_W-1:0]        best_first_next;
  logic [POS_W-1:0]        best_last_next;
  logic signed [SUM_W-1:0] sum_add;
  logic signed [63:0]      best_wide;
  logic                    out_free;
  logic                    finish;

  // A last beat needs the result register; other beats never wait.
  assign out_free = !out_valid || pop;
  assign take     = head_valid && (!head_flags.is_last || out_free);
  assign finish   = take && head_flags.is_last;
  assign sum_add  = run_sum + SUM_W'(head_sample);

  always_comb begin
    run_sum_next    = run_sum;
    run_start_next  = run_start;
    best_next       = best;
    best_first_next = best_first;
    best_last_next  = best_last;
    if (take && head_flags.counted) begin
      // Strictly greater, so the earliest run wins a tie.
      if (sum_add > best) begin
        best_next       = sum_add;
        best_first_next = run_start;
        best_last_next  = head_pos;
      end
      if (sum_add[SUM_W-1]) begin
        run_sum_next   = '0;
        run_start_next = head_pos + POS_W'(1);
      end else begin
        run_sum_next = sum_add;
      end
    end
  end

  assign best_wide = 64'(best_next);

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      run_sum    <= '0;
      run_start  <= POS_W'(1);
      best       <= '0;
      best_first <= '0;
      best_last  <= '0;
    end else begin
      run_sum    <= run_sum_next;
      run_start  <= run_start_next;
      best       <= best_next;
      best_first <= best_first_next;
      best_last  <= best_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (best_wide > 64'(msa_pkg::SUM_OUT_MAX)) begin
        best_sum <= msa_pkg::SUM_OUT_MAX;
      end else begin
        best_sum <= best_wide[msa_pkg::SUM_OUT_W-1:0];
      end
      best_start <= msa_pkg::POS_OUT_W'(best_first_next);
      best_end   <= msa_pkg::POS_OUT_W'(best_last_next);
    end
  end

  assign empty = !out_valid;

  `MSA_ASSERT_ALWAYS(a_best_not_negative, !best[SUM_W-1], "best sum went negative")
  `MSA_ASSERT_ALWAYS(a_best_order, best_first <= best_last, "best run starts after its end")
  `MSA_ASSERT_NEXT(a_clear_after_last, finish,
    run_sum == '0 && best == '0 && best_last == '0 && run_start == POS_W'(1),
    "scan state not cleared after a sequence ended")

endmodule

FILE: tb/tb_max_subarray_sum.sv
// Self-checking testbench for the maximum contiguous run sum block.
`timescale 1ns / 100ps

module tb_max_subarray_sum;

  // The block is built with its default sizes. The run-sum check below
  // follows these two values.
  localparam int unsigned MAX_LEN  = 65536;
  localparam int unsigned SAMPLE_W = 16;

  localparam int unsigned SUM_W = msa_pkg::SUM_OUT_W;
  localparam int unsigned POS_W = msa_pkg::POS_OUT_W;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32767;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -32768;

  // A result reaches the output once the last beat of its sequence has passed
  // the queue and the result register; the settle time follows a drain.
  localparam int SETTLE_CYCLES = 10;
  // The longest correct stretch without a beat is the receiver hold below.
  // The watchdog allows several times that.
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // Mixes of sample values that the random sequences draw from.
  typedef enum int unsigned {
    MIX_SMALL,     // small values of either sign, so ties and zero sums are common
    MIX_NEGATIVE,  // mostly negative, so runs restart often
    MIX_EXTREME,   // the two extremes of the sample range, or any 16-bit value
    MIX_FULL       // any 16-bit value
  } sample_mix_t;

  // One expected result: the best run of a finished sequence.
  typedef struct packed {
    logic [SUM_W-1:0] run_total;
    logic [POS_W-1:0] run_begin;
    logic [POS_W-1:0] run_end;
  } run_result_t;

  // Scoreboard. It keeps its own running-sum scan and the results that are
  // still awaited, oldest first.
  class kadane_scoreboard;
    run_result_t      expected_runs[$];
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] run_first;
    logic [POS_W-1:0] best_first;
    logic [POS_W-1:0] best_last;
    longint           run_sum;
    longint           best_total;
    int               errors;
    int               results_seen;
    int               samples_seen;
    int               sequences_seen;

    function new();
      errors          = 0;
      results_seen    = 0;
      samples_seen    = 0;
      sequences_seen  = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      position   = '0;
      run_sum    = 0;
      run_first  = POS_W'(1);
      best_total = 0;
      best_first = '0;
      best_last  = '0;
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("ERROR at %0t ns: %s", $time, msg);
      end
    endtask

    // Record one accepted input beat. If it ends the sequence, queue the expected result.
    function void take_sample(logic signed [SAMPLE_W-1:0] value, logic last);
      run_result_t r;
      samples_seen++;
      if (position < MAX_LEN) begin
        position++;
        run_sum += value;
        // The comparison is strict, so a later run with an equal sum does not
        // replace the earlier one.
        if (run_sum > best_total) begin
          best_total = run_sum;
          best_first = run_first;
          best_last  = position;
        end
        // A sum of exactly zero does not restart the run.
        if (run_sum < 0) begin
          run_sum   = 0;
          run_first = position + 1'b1;
        end
      end
      if (last) begin
        r.run_total = (best_total > longint'(msa_pkg::SUM_OUT_MAX)) ?
                      msa_pkg::SUM_OUT_MAX : best_total[SUM_W-1:0];
        r.run_begin = best_first;
        r.run_end   = best_last;
        expected_runs.insert(expected_runs.size(), r);
        sequences_seen++;
        clear_sequence();
      end
    endfunction

    // Compare one accepted result with the oldest expected result.
    task check_run(logic [SUM_W-1:0] got_total, logic [POS_W-1:0] got_begin,
                   logic [POS_W-1:0] got_end);
      run_result_t want;
      if (expected_runs.size() == 0) begin
        report($sformatf("result (%0d, %0d, %0d) with nothing expected",
                         got_total, got_begin, got_end));
        return;
      end
      want = expected_runs.pop_front();
      results_seen++;
      if (got_total !== want.run_total) begin
        report($sformatf("best_sum %0d, expected %0d", got_total, want.run_total));
      end
      if (got_begin !== want.run_begin) begin
        report($sformatf("best_start %0d, expected %0d", got_begin, want.run_begin));
      end
      if (got_end !== want.run_end) begin
        report($sformatf("best_end %0d, expected %0d", got_end, want.run_end));
      end
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       push;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       is_last;
  logic                       empty;
  logic                       pop;
  logic [SUM_W-1:0]           best_sum;
  logic [POS_W-1:0]           best_start;
  logic [POS_W-1:0]           best_end;

  kadane_scoreboard sb;

  // Idling rates in percent. They are changed only between phases.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // Each increment asks the receiver for one long hold.
  int          hold_requests;
  int          idle_cycles;

  max_subarray_sum #(
    .MAX_LENGTH   (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample     (sample),
    .is_last    (is_last),
    .empty      (empty),
    .pop        (pop),
    .best_sum   (best_sum),
    .best_start (best_start),
    .best_end   (best_end)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver. Each result is checked at the edge that accepts it. Pop for
  // the next cycle is then chosen. A hold request keeps pop low while a
  // counter, loaded from HOLD_CYCLES, counts down here.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        sb.check_run(best_sum, best_start, best_end);
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog. It counts cycles in which no beat moves on either side. A
  // hung handshake ends the run here.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles at %0t ns", WATCHDOG_LIMIT, $time);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one beat and return at the edge that accepts it. Push stays high
  // on return, so the next call either holds it or lowers it for an idle
  // cycle. Each time step has only one assignment to push.
  task automatic send_beat(input logic signed [SAMPLE_W-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    sample  <= value;
    is_last <= last;
    do @(posedge clk); while (full);
    sb.take_sample(value, last);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_mix_t mix);
    int v;
    case (mix)
      MIX_SMALL:    v = int'($urandom_range(40)) - 20;
      MIX_NEGATIVE: v = int'($urandom_range(60)) - 50;
      MIX_EXTREME: begin
        case ($urandom_range(3))
          0:       v = SAMPLE_MAX;
          1:       v = SAMPLE_MIN;
          default: v = $urandom;
        endcase
      end
      default:      v = $urandom;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_sequence(input int len, input sample_mix_t mix);
    for (int i = 0; i < len; i++) begin
      send_beat(pick_sample(mix), i == len - 1);
    end
  endtask

  // Random sequences until about the given number of beats have been sent.
  // Most sequences are short, so results come often. A few are long
  // enough for the best run to sit deep inside them.
  task automatic send_random(input int beats);
    int sent;
    int sel;
    int len;
    sent = 0;
    while (sent < beats) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        len = $urandom_range(6, 1);
      end else if (sel < 90) begin
        len = $urandom_range(30, 7);
      end else begin
        len = $urandom_range(120, 31);
      end
      send_sequence(len, sample_mix_t'($urandom_range(3)));
      sent += len;
    end
  endtask

  // Pause the sender until every awaited result has arrived. Then let the
  // block settle.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb             = new();
    send_idle_pct  = 8;
    recv_stall_pct = 68;
    hold_requests  <= 0;
    idle_cycles    <= 0;
    rst            <= 1'b1;
    push           <= 1'b0;
    sample         <= '0;
    is_last        <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed cases. First, single-sample sequences at the extremes, at zero and at -1.
    // No sum is positive for the minimum, for zero and for -1, so the empty run is
    // the result.
    send_beat(SAMPLE_MAX, 1'b1);
    send_beat(SAMPLE_MIN, 1'b1);
    send_beat(SAMPLE_W'(0), 1'b1);
    send_beat(SAMPLE_W'(-1), 1'b1);
    // Equal sums: the second run of 5 must not replace the first. The sum
    // returns to zero between them without a restart.
    send_beat(SAMPLE_W'(5), 1'b0);
    send_beat(SAMPLE_W'(-5), 1'b0);
    send_beat(SAMPLE_W'(5), 1'b1);
    // A zero running sum carries on, so the best run grows from position 1.
    send_beat(SAMPLE_W'(3), 1'b0);
    send_beat(SAMPLE_W'(-3), 1'b0);
    send_beat(SAMPLE_W'(4), 1'b1);
    // A negative running sum restarts the run at the next position.
    send_beat(SAMPLE_W'(-1), 1'b0);
    send_beat(SAMPLE_W'(2), 1'b0);
    send_beat(SAMPLE_W'(3), 1'b1);
    send_beat(SAMPLE_W'(1), 1'b0);
    send_beat(SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_W'(1), 1'b0);
    send_beat(SAMPLE_W'(1), 1'b1);
    // A sum well beyond the sample range.
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_W'(-1), 1'b1);

    // Phase one: the receiver stalls often and the sender seldom idles.
    send_random(460);
    drain();

    // Phase two: the sender idles often and the receiver seldom stalls.
    send_idle_pct  = 68;
    recv_stall_pct = 8;
    send_random(480);
    drain();

    // Phase three: neither side idles. The receiver holds off for a long
    // stretch while single-beat sequences keep arriving. The block must
    // fill up and hold full until pops resume.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    for (int k = 0; k < 40; k++) begin
      send_beat(pick_sample(MIX_FULL), 1'b1);
    end
    send_random(430);
    drain();

    $display("Covered %0d beats in %0d sequences, %0d results checked.",
             sb.samples_seen, sb.sequences_seen, sb.results_seen);
    $display("Idling ran both ways and not at all, with a long receiver hold that filled the block.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
